// ===== rtl/core/lfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfc_pkg: shared definitions for the cascaded PD line follower
// Field widths, fixed-point format, register indexes, reset values and the
// symmetric clamp used for both target speeds and drive values.
// ----------------------------------------------------------------------------
package lfc_pkg;

  // Sensor array
  localparam int SensorCount = 8;
  localparam int LineBitsW   = 8;
  localparam int UsedSensors = (SensorCount < LineBitsW) ? SensorCount : LineBitsW;
  localparam int SensorPitch = 1000;
  localparam int CenterPos   = 500 * (SensorCount + 1);

  // Weighted sum of the active sensors and the number of active sensors
  localparam int MaxSum = 500 * UsedSensors * (UsedSensors + 1);
  localparam int SumW   = $clog2(MaxSum + 1);
  localparam int CntW   = $clog2(UsedSensors + 1);

  // Line error covers center minus the outermost weight and the lost-line value
  localparam int LineErrMag = (SensorPitch * UsedSensors > CenterPos + 1) ?
                              SensorPitch * UsedSensors : CenterPos + 1;
  localparam int LineErrW   = $clog2(LineErrMag + 1) + 1;

  // Speeds, registers and gains
  localparam int SpdW      = 13;
  localparam int SpeedRegW = 12;
  localparam int GainW     = 20;
  localparam int FracW     = 16;
  localparam int InErrW    = SpdW + 1;

  // Multiplier operand, truncated product and accumulator widths
  localparam int OpW  = ((LineErrW > InErrW) ? LineErrW : InErrW) + 2;
  localparam int QW   = OpW + GainW - FracW + 1;
  localparam int AccW = QW + 3;

  // Stream payload widths, padded to whole bytes
  localparam int InDataW  = ((LineBitsW + 2 * SpdW + 7) / 8) * 8;
  localparam int OutDataW = ((2 * SpdW + 7) / 8) * 8;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = GainW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOuterProp  = 3'd0,
    CfgOuterDeriv = 3'd1,
    CfgErrSum     = 3'd2,
    CfgBaseLeft   = 3'd3,
    CfgBaseRight  = 3'd4,
    CfgMaxSpeed   = 3'd5,
    CfgInnerProp  = 3'd6,
    CfgInnerDeriv = 3'd7
  } cfg_idx_e;

  localparam logic [GainW-1:0]     RstOuterProp  = 20'd6095;
  localparam logic [GainW-1:0]     RstOuterDeriv = 20'd77988;
  localparam logic [GainW-1:0]     RstErrSum     = 20'd52;
  localparam logic [SpeedRegW-1:0] RstBaseLeft   = 12'd750;
  localparam logic [SpeedRegW-1:0] RstBaseRight  = 12'd750;
  localparam logic [SpeedRegW-1:0] RstMaxSpeed   = 12'd1000;
  localparam logic [GainW-1:0]     RstInnerProp  = 20'd65536;
  localparam logic [GainW-1:0]     RstInnerDeriv = 20'd32768;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp a signed value to [-lim, lim].
  function automatic logic signed [SpdW-1:0] clamp_sym(
    input logic signed [AccW-1:0] v,
    input logic [SpeedRegW-1:0]   lim
  );
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = $signed({{(AccW - SpeedRegW){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      clamp_sym = hi[SpdW-1:0];
    end else if (v < lo) begin
      clamp_sym = lo[SpdW-1:0];
    end else begin
      clamp_sym = v[SpdW-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/lfc_div.sv =====
// ----------------------------------------------------------------------------
// lfc_div: radix-2 restoring divider
// Divides the weighted sensor sum by the number of active sensors, one
// quotient bit per cycle, and flags the cycle in which the quotient is ready.
// ----------------------------------------------------------------------------
module lfc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lfc_pkg::SumW-1:0]      dividend_i,
  input  logic [lfc_pkg::CntW-1:0]      divisor_i,
  output lfc_pkg::div_stat_t            stat_o,
  output logic [lfc_pkg::SumW-1:0]      quotient_o
);

  localparam int StepW = $clog2(lfc_pkg::SumW + 1);

  logic                       run_q;
  logic [StepW-1:0]           steps_q;
  logic [lfc_pkg::CntW-1:0]   rem_q, rem_d;
  logic [lfc_pkg::SumW-1:0]   quot_q;
  logic [lfc_pkg::CntW-1:0]   dsr_q;
  logic [lfc_pkg::CntW:0]     trial;
  logic [lfc_pkg::CntW:0]     diff;
  logic                       fits;

  // The partial remainder stays below the divisor, so it needs CntW bits.
  always_comb begin
    trial = {rem_q, quot_q[lfc_pkg::SumW-1]};
    fits  = trial >= {1'b0, dsr_q};
    diff  = trial - {1'b0, dsr_q};
    rem_d = fits ? diff[lfc_pkg::CntW-1:0] : trial[lfc_pkg::CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      steps_q <= '0;
    end else if (start_i) begin
      run_q   <= 1'b1;
      steps_q <= StepW'(lfc_pkg::SumW);
    end else if (run_q) begin
      if (steps_q != '0) begin
        steps_q <= steps_q - StepW'(1);
      end else begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dsr_q  <= divisor_i;
    end else if (run_q && (steps_q != '0)) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[lfc_pkg::SumW-2:0], fits};
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = run_q && (steps_q == '0);
  assign quotient_o  = quot_q;

endmodule

// ===== rtl/core/lfc_qmul.sv =====
// ----------------------------------------------------------------------------
// lfc_qmul: shared Q4.16 gain multiplier
// Multiplies a signed operand by an unsigned Q4.16 gain and truncates the
// product toward zero. The result is registered and holds until the next load.
// ----------------------------------------------------------------------------
module lfc_qmul (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic signed [lfc_pkg::OpW-1:0]      value_i,
  input  logic [lfc_pkg::GainW-1:0]           gain_i,
  output logic signed [lfc_pkg::QW-1:0]       q_o
);

  localparam int ProdW = lfc_pkg::OpW + lfc_pkg::GainW;

  logic                         neg;
  logic [lfc_pkg::OpW-1:0]      mag_in;
  logic [ProdW-1:0]             prod;
  logic                         neg_q;
  logic [lfc_pkg::QW-2:0]       mag_q;
  logic signed [lfc_pkg::QW-1:0] mag_s;

  // Truncation toward zero: multiply the magnitude, drop the fraction,
  // then restore the sign.
  always_comb begin
    neg    = value_i[lfc_pkg::OpW-1];
    mag_in = neg ? lfc_pkg::OpW'(-value_i) : lfc_pkg::OpW'(value_i);
    prod   = ProdW'(mag_in) * ProdW'(gain_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      neg_q <= neg;
      mag_q <= prod[ProdW-1:lfc_pkg::FracW];
    end
  end

  assign mag_s = $signed({1'b0, mag_q});
  assign q_o   = neg_q ? -mag_s : mag_s;

endmodule

// ===== rtl/core/line_follow_cascade_pd.sv =====
// ----------------------------------------------------------------------------
// line_follow_cascade_pd: cascaded PD line follower controller
// Finds the line position from the sensor bits, runs the outer PD loop to
// get wheel target speeds and two inner PD loops to get the drive values.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake               Payload
//   s_axis    in         tvalid / tready         line_bits, measured_left/right
//   m_axis    out        tvalid / tready         drive_left/right, line_lost
//   cfg       in         cfg_valid / cfg_ready   register index, write data
//
// Each item passes through the bit-serial divider before the PD steps, and
// skips the divide step when no sensor bit is set.
// All seven gain products go through one shared multiplier, one per step.
// Reset clears the registers to their defaults and the stored errors to zero.
// The input is ready only while the sequencer is idle; a result waiting in the
// output register holds the sequencer in its last step until it is taken.
// ----------------------------------------------------------------------------
module line_follow_cascade_pd (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: line_bits [7:0], measured_left [20:8], measured_right [33:21]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lfc_pkg::InDataW-1:0]     s_axis_tdata,
  // tdata: drive_left [12:0], drive_right [25:13]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lfc_pkg::OutDataW-1:0]    m_axis_tdata,
  // tuser: line_lost [0]
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lfc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lfc_pkg::CfgDataW-1:0]    cfg_data_i
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DIV  = 13'b0000000000010,
    S_DER  = 13'b0000000000100,
    S_OMP  = 13'b0000000001000,
    S_OMD  = 13'b0000000010000,
    S_OMR  = 13'b0000000100000,
    S_TGT  = 13'b0000001000000,
    S_IERR = 13'b0000010000000,
    S_ILP  = 13'b0000100000000,
    S_ILD  = 13'b0001000000000,
    S_IRP  = 13'b0010000000000,
    S_IRD  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_e;

  localparam int LeW  = lfc_pkg::LineErrW;
  localparam int IeW  = lfc_pkg::InErrW;
  localparam int SpW  = lfc_pkg::SpdW;
  localparam int OpW  = lfc_pkg::OpW;
  localparam int AccW = lfc_pkg::AccW;
  localparam int QW   = lfc_pkg::QW;
  localparam logic signed [LeW-1:0] CenterErr = LeW'(lfc_pkg::CenterPos);
  localparam logic signed [LeW-1:0] LostErr   = LeW'(lfc_pkg::CenterPos + 1);

  state_e state_q, state_d;

  // Configuration registers
  logic [lfc_pkg::GainW-1:0]     opg_q, odg_q, esg_q, ipg_q, idg_q;
  logic [lfc_pkg::SpeedRegW-1:0] base_l_q, base_r_q, max_q;

  // Loop state
  logic signed [LeW-1:0] prev_line_q;
  logic signed [IeW-1:0] prev_l_q, prev_r_q;

  // Per-item working registers
  logic signed [SpW-1:0]  meas_l_q, meas_r_q;
  logic                   lost_q;
  logic signed [LeW-1:0]  err_q;
  logic signed [LeW:0]    der_q;
  logic [LeW-1:0]         rsum_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [SpW-1:0]  tl_q, tr_q, drv_l_q;
  logic signed [IeW-1:0]  el_q, er_q;
  logic signed [IeW:0]    dl_q, dr_q;

  // Output register
  logic                   out_valid_q;
  logic signed [SpW-1:0]  out_l_q, out_r_q;
  logic                   out_lost_q;

  // Input fields and sensor reduction
  logic [lfc_pkg::LineBitsW-1:0] line_bits;
  logic signed [SpW-1:0]         meas_l_in, meas_r_in;
  logic [lfc_pkg::SumW-1:0]      wsum;
  logic [lfc_pkg::CntW-1:0]      hits;
  logic                          in_fire;

  // Shared units
  lfc_pkg::div_stat_t         div_stat;
  logic [lfc_pkg::SumW-1:0]   quotient;
  logic                       div_start;
  logic                       mul_load;
  logic signed [OpW-1:0]      mul_val;
  logic [lfc_pkg::GainW-1:0]  mul_gain;
  logic signed [QW-1:0]       mul_q;
  logic signed [AccW-1:0]     mul_ext;

  // Combinational datapath helpers
  logic [LeW-1:0]         abs_err, abs_prev;
  logic signed [AccW-1:0] tgt_l, tgt_r, drv_sum;
  logic signed [IeW-1:0]  el_d, er_d;
  logic                   out_load;

  assign line_bits = s_axis_tdata[lfc_pkg::LineBitsW-1:0];
  assign meas_l_in = $signed(s_axis_tdata[lfc_pkg::LineBitsW +: SpW]);
  assign meas_r_in = $signed(s_axis_tdata[lfc_pkg::LineBitsW + SpW +: SpW]);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    wsum = '0;
    hits = '0;
    for (int k = 0; k < lfc_pkg::UsedSensors; k++) begin
      if (line_bits[k]) begin
        wsum = wsum + lfc_pkg::SumW'(lfc_pkg::SensorPitch * (k + 1));
        hits = hits + lfc_pkg::CntW'(1);
      end
    end
  end

  assign div_start = in_fire && (hits != '0);

  lfc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wsum),
    .divisor_i  (hits),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Operand selection for the shared multiplier
  always_comb begin
    mul_load = 1'b1;
    mul_val  = '0;
    mul_gain = '0;
    case (state_q)
      S_OMP: begin
        mul_val  = {{(OpW - LeW){err_q[LeW-1]}}, err_q};
        mul_gain = opg_q;
      end
      S_OMD: begin
        mul_val  = {{(OpW - LeW - 1){der_q[LeW]}}, der_q};
        mul_gain = odg_q;
      end
      S_OMR: begin
        mul_val  = $signed({{(OpW - LeW){1'b0}}, rsum_q});
        mul_gain = esg_q;
      end
      S_ILP: begin
        mul_val  = {{(OpW - IeW){el_q[IeW-1]}}, el_q};
        mul_gain = ipg_q;
      end
      S_ILD: begin
        mul_val  = {{(OpW - IeW - 1){dl_q[IeW]}}, dl_q};
        mul_gain = idg_q;
      end
      S_IRP: begin
        mul_val  = {{(OpW - IeW){er_q[IeW-1]}}, er_q};
        mul_gain = ipg_q;
      end
      S_IRD: begin
        mul_val  = {{(OpW - IeW - 1){dr_q[IeW]}}, dr_q};
        mul_gain = idg_q;
      end
      default: begin
        mul_load = 1'b0;
      end
    endcase
  end

  lfc_qmul u_qmul (
    .clk_i   (clk_i),
    .load_i  (mul_load),
    .value_i (mul_val),
    .gain_i  (mul_gain),
    .q_o     (mul_q)
  );

  assign mul_ext = {{(AccW - QW){mul_q[QW-1]}}, mul_q};

  // Datapath arithmetic used by single sequencer steps
  always_comb begin
    abs_err  = err_q[LeW-1] ? LeW'(-err_q) : LeW'(err_q);
    abs_prev = prev_line_q[LeW-1] ? LeW'(-prev_line_q) : LeW'(prev_line_q);
    tgt_l    = $signed({{(AccW - lfc_pkg::SpeedRegW){1'b0}}, base_l_q}) + acc_q - mul_ext;
    tgt_r    = $signed({{(AccW - lfc_pkg::SpeedRegW){1'b0}}, base_r_q}) - acc_q - mul_ext;
    el_d     = {tl_q[SpW-1], tl_q} - {meas_l_q[SpW-1], meas_l_q};
    er_d     = {tr_q[SpW-1], tr_q} - {meas_r_q[SpW-1], meas_r_q};
    drv_sum  = acc_q + mul_ext;
  end

  assign out_load = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (hits == '0) ? S_DER : S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_DER;
        end
      end
      S_DER:  state_d = S_OMP;
      S_OMP:  state_d = S_OMD;
      S_OMD:  state_d = S_OMR;
      S_OMR:  state_d = S_TGT;
      S_TGT:  state_d = S_IERR;
      S_IERR: state_d = S_ILP;
      S_ILP:  state_d = S_ILD;
      S_ILD:  state_d = S_IRP;
      S_IRP:  state_d = S_IRD;
      S_IRD:  state_d = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opg_q    <= lfc_pkg::RstOuterProp;
      odg_q    <= lfc_pkg::RstOuterDeriv;
      esg_q    <= lfc_pkg::RstErrSum;
      base_l_q <= lfc_pkg::RstBaseLeft;
      base_r_q <= lfc_pkg::RstBaseRight;
      max_q    <= lfc_pkg::RstMaxSpeed;
      ipg_q    <= lfc_pkg::RstInnerProp;
      idg_q    <= lfc_pkg::RstInnerDeriv;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (lfc_pkg::cfg_idx_e'(cfg_index_i))
        lfc_pkg::CfgOuterProp:  opg_q    <= cfg_data_i;
        lfc_pkg::CfgOuterDeriv: odg_q    <= cfg_data_i;
        lfc_pkg::CfgErrSum:     esg_q    <= cfg_data_i;
        lfc_pkg::CfgBaseLeft:   base_l_q <= cfg_data_i[lfc_pkg::SpeedRegW-1:0];
        lfc_pkg::CfgBaseRight:  base_r_q <= cfg_data_i[lfc_pkg::SpeedRegW-1:0];
        lfc_pkg::CfgMaxSpeed:   max_q    <= cfg_data_i[lfc_pkg::SpeedRegW-1:0];
        lfc_pkg::CfgInnerProp:  ipg_q    <= cfg_data_i;
        lfc_pkg::CfgInnerDeriv: idg_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stored errors carried from one item to the next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_line_q <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      if (state_q == S_DER) begin
        prev_line_q <= err_q;
      end
      if (state_q == S_IERR) begin
        prev_l_q <= el_d;
        prev_r_q <= er_d;
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meas_l_q <= meas_l_in;
      meas_r_q <= meas_r_in;
      lost_q   <= (hits == '0);
      err_q    <= LostErr;
    end
    if ((state_q == S_DIV) && div_stat.done) begin
      err_q <= CenterErr - $signed({1'b0, quotient[LeW-2:0]});
    end
    if (state_q == S_DER) begin
      der_q  <= {err_q[LeW-1], err_q} - {prev_line_q[LeW-1], prev_line_q};
      rsum_q <= abs_err + abs_prev;
    end
    if ((state_q == S_OMD) || (state_q == S_ILD) || (state_q == S_IRD)) begin
      acc_q <= mul_ext;
    end
    if (state_q == S_OMR) begin
      acc_q <= acc_q + mul_ext;
    end
    if (state_q == S_TGT) begin
      tl_q <= lfc_pkg::clamp_sym(tgt_l, max_q);
      tr_q <= lfc_pkg::clamp_sym(tgt_r, max_q);
    end
    if (state_q == S_IERR) begin
      el_q <= el_d;
      er_q <= er_d;
      dl_q <= {el_d[IeW-1], el_d} - {prev_l_q[IeW-1], prev_l_q};
      dr_q <= {er_d[IeW-1], er_d} - {prev_r_q[IeW-1], prev_r_q};
    end
    if (state_q == S_IRP) begin
      drv_l_q <= lfc_pkg::clamp_sym(drv_sum, max_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_l_q    <= drv_l_q;
      out_r_q    <= lfc_pkg::clamp_sym(drv_sum, max_q);
      out_lost_q <= lost_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lfc_pkg::OutDataW - 2 * SpW){1'b0}}, out_r_q, out_l_q};
  assign m_axis_tuser  = out_lost_q;

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input ready right after an accepted transaction");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_div_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> div_stat.busy)
    else $error("sequencer waits on an idle divider");

endmodule
